// ===== hw/rtl/tde_pkg.sv =====
package tde_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam logic [31:0] MAX_SAMPLES_RESET = 32'hFFFF_FFFF;

    localparam logic [7:0] ESCAPE_BYTE = 8'h80;
    localparam int DELTA_LIMIT = 127;

    // word_kind codes on the result channel
    localparam logic [1:0] KIND_DELTA  = 2'd0;
    localparam logic [1:0] KIND_ESCAPE = 2'd1;
    localparam logic [1:0] KIND_RAW_LO = 2'd2;
    localparam logic [1:0] KIND_RAW_HI = 2'd3;

    // what the back end has to emit for one sample
    typedef enum logic [1:0] {
        CLS_DELTA  = 2'd0,
        CLS_ESCAPE = 2'd1,
        CLS_RAW    = 2'd2
    } cmd_class_t;

    typedef struct packed {
        cmd_class_t  cls;
        logic [23:0] deltas;   // z, y, x from high to low
        logic [47:0] sample;   // z, y, x from high to low
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

// ===== hw/rtl/tde_front.sv =====
module tde_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [47:0]          s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic [31:0]          max_samples,
    input  tde_pkg::queue_stat_t q_stat,
    output logic                 push,
    output tde_pkg::cmd_t        push_cmd
);

    logic [47:0] prev_reg, prev_next;
    logic [31:0] seen_reg, seen_next;
    logic        open_reg, open_next;

    logic               accept;
    logic               new_stream;
    logic               limit_hit;
    logic signed [16:0] dx, dy, dz;
    logic               in_rng;

    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;

    assign new_stream = s_tuser[0] || !open_reg;
    assign limit_hit  = (seen_reg >= max_samples);
    assign push       = accept && (new_stream || !limit_hit);

    assign dx = $signed({1'b0, s_tdata[15:0]})  - $signed({1'b0, prev_reg[15:0]});
    assign dy = $signed({1'b0, s_tdata[31:16]}) - $signed({1'b0, prev_reg[31:16]});
    assign dz = $signed({1'b0, s_tdata[47:32]}) - $signed({1'b0, prev_reg[47:32]});

    // -128 is escaped too: 0x80 is reserved for the escape word
    assign in_rng = (dx >= -17'(tde_pkg::DELTA_LIMIT)) && (dx <= 17'(tde_pkg::DELTA_LIMIT))
                 && (dy >= -17'(tde_pkg::DELTA_LIMIT)) && (dy <= 17'(tde_pkg::DELTA_LIMIT))
                 && (dz >= -17'(tde_pkg::DELTA_LIMIT)) && (dz <= 17'(tde_pkg::DELTA_LIMIT));

    always_comb begin
        push_cmd.deltas = {dz[7:0], dy[7:0], dx[7:0]};
        push_cmd.sample = s_tdata;
        if (new_stream) begin
            push_cmd.cls = tde_pkg::CLS_RAW;
        end else if (in_rng) begin
            push_cmd.cls = tde_pkg::CLS_DELTA;
        end else begin
            push_cmd.cls = tde_pkg::CLS_ESCAPE;
        end
    end

    always_comb begin
        prev_next = prev_reg;
        seen_next = seen_reg;
        open_next = open_reg;
        if (push) begin
            prev_next = s_tdata;
            open_next = 1'b1;
            seen_next = new_stream ? 32'd1 : seen_reg + 32'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            seen_reg <= '0;
            open_reg <= 1'b0;
        end else begin
            prev_reg <= prev_next;
            seen_reg <= seen_next;
            open_reg <= open_next;
        end
    end

endmodule

// ===== hw/rtl/tde_queue.sv =====
module tde_queue #(
    parameter int unsigned DEPTH = tde_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tde_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output tde_pkg::cmd_t        head_cmd,
    output tde_pkg::queue_stat_t stat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tde_pkg::cmd_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head_cmd   = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/tde_back.sv =====
module tde_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tde_pkg::cmd_t        head_cmd,
    input  tde_pkg::queue_stat_t q_stat,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast
);

    logic [1:0]  phase_reg, phase_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        load;
    logic [23:0] word_data;
    logic [1:0]  word_kind;
    logic        word_last;
    logic [23:0] raw_lo, raw_hi;

    assign raw_lo = {head_cmd.sample[23:16], head_cmd.sample[15:8], head_cmd.sample[7:0]};
    assign raw_hi = {head_cmd.sample[47:40], head_cmd.sample[39:32], head_cmd.sample[31:24]};

    always_comb begin
        word_data = raw_hi;
        word_kind = tde_pkg::KIND_RAW_HI;
        word_last = 1'b1;
        unique case (head_cmd.cls)
            tde_pkg::CLS_DELTA: begin
                word_data = head_cmd.deltas;
                word_kind = tde_pkg::KIND_DELTA;
            end
            tde_pkg::CLS_ESCAPE: begin
                if (phase_reg == 2'd0) begin
                    word_data = {3{tde_pkg::ESCAPE_BYTE}};
                    word_kind = tde_pkg::KIND_ESCAPE;
                    word_last = 1'b0;
                end else if (phase_reg == 2'd1) begin
                    word_data = raw_lo;
                    word_kind = tde_pkg::KIND_RAW_LO;
                    word_last = 1'b0;
                end
            end
            tde_pkg::CLS_RAW: begin
                if (phase_reg == 2'd0) begin
                    word_data = raw_lo;
                    word_kind = tde_pkg::KIND_RAW_LO;
                    word_last = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // output register frees whenever its word is taken
    assign load = (!m_tvalid_reg || m_tready) && !q_stat.empty;
    assign pop  = load && word_last;

    always_comb begin
        phase_next    = phase_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = word_data;
            m_tuser_next  = word_kind;
            m_tlast_next  = word_last;
            phase_next    = word_last ? 2'd0 : phase_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ===== hw/rtl/triaxial_delta_encoder_unit.sv =====
// Channel   Dir  Ports                          Contents
// s_        in   tvalid/tready/tdata/tuser      one three-axis sample per transaction
// m_        out  tvalid/tready/tdata/tuser/tlast one 3-byte output word per transaction
// cfg_      in   we/wdata                       max_samples register write
//
// One sample is taken per cycle while the command queue has room. A delta sample gives
// one word, a first sample two, an escaped one three; the output register issues one
// word per cycle while m_ is not stalled, and the queue soaks up the multi-word bursts.
// A sample's first word goes into the command queue, then into the output register.
// Reset (aresetn low, synchronous) empties the queue, closes the stream, clears the
// count and sets max_samples to all ones. A stalled m_ side fills the queue and then
// drops s_tready; samples past the limit are consumed silently.
module triaxial_delta_encoder_unit #(
    parameter int unsigned QUEUE_DEPTH = tde_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample_x[15:0], sample_y[31:16], sample_z[47:32]
    input  logic [0:0]  s_tuser,   // stream_start[0]
    // encoded word output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // byte_a[7:0], byte_b[15:8], byte_c[23:16]
    output logic [1:0]  m_tuser,   // word_kind[1:0]
    output logic        m_tlast,   // run_last: last word of this sample
    // configuration
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata  // max_samples
);

    logic [31:0] max_samples_reg, max_samples_next;

    tde_pkg::queue_stat_t q_stat;
    tde_pkg::cmd_t        push_cmd;
    tde_pkg::cmd_t        head_cmd;
    logic                 push;
    logic                 pop;

    // config register; to be written only while the block is idle (not enforced here)
    assign max_samples_next = cfg_we ? cfg_wdata : max_samples_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_samples_reg <= tde_pkg::MAX_SAMPLES_RESET;
        end else begin
            max_samples_reg <= max_samples_next;
        end
    end

    // front: stream state, delta range check, classification
    tde_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .max_samples (max_samples_reg),
        .q_stat      (q_stat),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // command queue decouples sample intake from word issue
    tde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    // back: expands each command into its words
    tde_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/tde_checker.sv =====
module tde_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // held word must not change while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // only delta and raw-high words close a sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == ((m_tuser == tde_pkg::KIND_DELTA)
                                  || (m_tuser == tde_pkg::KIND_RAW_HI))))
        else $error("tlast does not match word kind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tde_pkg::KIND_ESCAPE)
            |-> (m_tdata == {3{tde_pkg::ESCAPE_BYTE}}))
        else $error("escape word with wrong bytes");

    // a delta byte never collides with the escape marker
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == tde_pkg::KIND_DELTA)
            |-> (m_tdata[7:0] != tde_pkg::ESCAPE_BYTE)
             && (m_tdata[15:8] != tde_pkg::ESCAPE_BYTE)
             && (m_tdata[23:16] != tde_pkg::ESCAPE_BYTE))
        else $error("delta byte equals escape marker");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

endmodule

bind triaxial_delta_encoder_unit tde_checker u_tde_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== bench/tde_checker.sv =====
module tb_tde_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    output int          errors,
    output int          words_outstanding,
    output int          words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [1:0] kind;
        logic       last;
    } enc_word_t;

    enc_word_t   pending_words[$];

    // encoder state mirror
    logic [15:0] last_x, last_y, last_z;
    logic [31:0] seen_count;
    logic        stream_live;
    logic [31:0] sample_limit;

    function automatic enc_word_t make_word(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                            logic [1:0] kind, logic last);
        enc_word_t w;
        w.byte_a = a;
        w.byte_b = b;
        w.byte_c = c;
        w.kind   = kind;
        w.last   = last;
        return w;
    endfunction

    function automatic logic fits_delta(int d);
        return (d >= -tde_pkg::DELTA_LIMIT) && (d <= tde_pkg::DELTA_LIMIT);
    endfunction

    task automatic push_raw(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        pending_words.push_back(make_word(x[7:0], x[15:8], y[7:0],
                                          tde_pkg::KIND_RAW_LO, 1'b0));
        pending_words.push_back(make_word(y[15:8], z[7:0], z[15:8],
                                          tde_pkg::KIND_RAW_HI, 1'b1));
    endtask

    task automatic encode_sample(logic start, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        int   dx, dy, dz;
        logic taken;
        taken = 1'b1;
        if (start || !stream_live) begin
            push_raw(x, y, z);
            stream_live = 1'b1;
            seen_count  = 32'd1;
        end else if (seen_count < sample_limit) begin
            dx = int'(x) - int'(last_x);
            dy = int'(y) - int'(last_y);
            dz = int'(z) - int'(last_z);
            if (fits_delta(dx) && fits_delta(dy) && fits_delta(dz)) begin
                pending_words.push_back(make_word(dx[7:0], dy[7:0], dz[7:0],
                                                  tde_pkg::KIND_DELTA, 1'b1));
            end else begin
                pending_words.push_back(make_word(tde_pkg::ESCAPE_BYTE, tde_pkg::ESCAPE_BYTE,
                                                  tde_pkg::ESCAPE_BYTE,
                                                  tde_pkg::KIND_ESCAPE, 1'b0));
                push_raw(x, y, z);
            end
            seen_count = seen_count + 32'd1;
        end else begin
            taken = 1'b0;   // past the limit: consumed, no words, no state change
        end
        if (taken) begin
            last_x = x;
            last_y = y;
            last_z = z;
        end
    endtask

    task automatic report(string what, enc_word_t exp_w, enc_word_t got_w);
        errors = errors + 1;
        if (errors <= 10) begin
            $write("%0t %s: expected a=%h b=%h c=%h kind=%0d last=%b,",
                   $time, what, exp_w.byte_a, exp_w.byte_b, exp_w.byte_c, exp_w.kind,
                   exp_w.last);
            $display(" got a=%h b=%h c=%h kind=%0d last=%b",
                     got_w.byte_a, got_w.byte_b, got_w.byte_c, got_w.kind, got_w.last);
        end
    endtask

    always @(posedge aclk) begin : monitor
        enc_word_t exp_w;
        enc_word_t got_w;
        if (!aresetn) begin
            pending_words.delete();
            last_x        = '0;
            last_y        = '0;
            last_z        = '0;
            seen_count    = '0;
            stream_live   = 1'b0;
            sample_limit  = tde_pkg::MAX_SAMPLES_RESET;
            errors        = 0;
            words_checked = 0;
        end else begin
            if (cfg_we) begin
                sample_limit = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                encode_sample(s_tuser[0], s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
            end
            if (m_tvalid && m_tready) begin
                got_w = make_word(m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser, m_tlast);
                if (pending_words.size() == 0) begin
                    report("word with nothing expected", '0, got_w);
                end else begin
                    exp_w = pending_words.pop_front();
                    words_checked = words_checked + 1;
                    if (got_w != exp_w) begin
                        report("word mismatch", exp_w, got_w);
                    end
                end
            end
        end
        words_outstanding <= pending_words.size();
    end

endmodule

// ===== bench/tb_triaxial_delta_encoder_unit.sv =====
module tb_triaxial_delta_encoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 200000;  // watchdog
    localparam int SETTLE       = 8;       // wait in drain after the last expected word
    localparam int HOLD_CYCLES  = 80;      // long receiver hold-off, fills the queue

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;   // sample_x[15:0], sample_y[31:16], sample_z[47:32]
    logic [0:0]  s_tuser   = '0;   // stream_start[0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;          // byte_a[7:0], byte_b[15:8], byte_c[23:16]
    logic [1:0]  m_tuser;          // word_kind[1:0]
    logic        m_tlast;          // run_last
    logic        cfg_we    = 1'b0;
    logic [31:0] cfg_wdata = '0;   // max_samples

    int errors;
    int words_outstanding;
    int words_checked;

    int cycle_count    = 0;
    int samples_sent   = 0;
    int limits_written = 0;
    int holds_done     = 0;

    // idling controls shared by the two driver processes
    logic quiet    = 1'b0;   // last part of the run: no idling on either side
    logic gaps_on  = 1'b1;   // sender gaps, enabled at random per stream
    logic hold_req = 1'b0;   // asks the receiver for one long hold-off

    always #10ns aclk = ~aclk;

    triaxial_delta_encoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Watches both channels and the register port, predicts and compares.
    tb_tde_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .errors            (errors),
        .words_outstanding (words_outstanding),
        .words_checked     (words_checked)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, words_outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver side. Short random stalls, one long hold-off on request (counted
    // here) so the sender backs up into a full queue, and no stalls at all once
    // quiet is set.
    initial begin : receiver
        int n;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge aclk);
                end
                holds_done++;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // One sample transaction. Called right after a rising edge; returns right
    // after the edge that accepted it with valid still high, or after a gap with valid low.
    task automatic send_sample(logic start, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        s_tvalid   <= 1'b1;
        s_tuser[0] <= start;
        s_tdata    <= {z, y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
        if (gaps_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    // Drain: nothing expected, then extra cycles since dropped samples leave
    // no word behind but may still be in flight.
    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_limit(logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        limits_written++;
    endtask

    // Next value of one axis: mostly a small step, sometimes the delta range
    // edges (+-127 fits, +-128 escapes) or a jump anywhere. Steps wrap at 16 bits.
    function automatic logic [15:0] step_axis(logic [15:0] v);
        case ($urandom_range(0, 39))
            0:       return 16'($urandom);
            1:       return v + 16'd128;
            2:       return v - 16'd128;
            3:       return v + 16'd127;
            4:       return v - 16'd127;
            default: return v + 16'($urandom_range(0, 254)) - 16'd127;
        endcase
    endfunction

    // Random part: streams that open with stream_start and then walk, with
    // the odd restart and the odd unrelated sample mixed in.
    task automatic run_streams(int n_items);
        int          left;
        int          len;
        int          k;
        logic [15:0] x, y, z;
        left = n_items;
        while (left > 0) begin
            len     = $urandom_range(1, 24);
            gaps_on = ($urandom_range(0, 2) != 0);
            x = 16'($urandom);
            y = 16'($urandom);
            z = 16'($urandom);
            send_sample(1'b1, x, y, z);
            left--;
            for (k = 1; k < len && left > 0; k++) begin
                if ($urandom_range(0, 19) == 0) begin
                    x = 16'($urandom);
                    y = 16'($urandom);
                    z = 16'($urandom);
                end else begin
                    x = step_axis(x);
                    y = step_axis(y);
                    z = step_axis(z);
                end
                send_sample($urandom_range(0, 29) == 0, x, y, z);
                left--;
            end
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset limit (all ones).
        send_sample(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF);  // no open stream yet: raw
        send_sample(1'b0, 16'hFF80, 16'h007F, 16'hFF80);  // -127, +127, -127
        send_sample(1'b0, 16'hFF80, 16'h007F, 16'hFF80);  // all zero deltas
        send_sample(1'b0, 16'hFF00, 16'h007F, 16'hFF80);  // x -128: escape
        send_sample(1'b0, 16'hFF80, 16'h007F, 16'hFF80);  // x +128: escape
        send_sample(1'b0, 16'hFF80, 16'hFFFF, 16'hFF80);  // y far off
        send_sample(1'b0, 16'hFF80, 16'hFF7F, 16'hFF80);  // y -128
        send_sample(1'b0, 16'hFF80, 16'hFF7F, 16'hFF00);  // z -128
        send_sample(1'b0, 16'hFF80, 16'hFF7F, 16'hFF7F);  // z +127: delta
        send_sample(1'b1, 16'h1234, 16'h5678, 16'h9ABC);  // restart mid-stream
        send_sample(1'b1, 16'h0000, 16'h0000, 16'h0000);  // restart again
        send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // full-scale jump up
        send_sample(1'b0, 16'h0000, 16'h0000, 16'h0000);  // and back down
        send_sample(1'b0, 16'h007F, 16'h0001, 16'h0000);
        send_sample(1'b0, 16'h5555, 16'hAAAA, 16'h5555);

        // Limit of 3: two deltas after the first, then drops until a restart.
        write_limit(32'd3);
        send_sample(1'b1, 16'h0100, 16'h0200, 16'h0300);
        send_sample(1'b0, 16'h0101, 16'h0201, 16'h0301);
        send_sample(1'b0, 16'h0102, 16'h0202, 16'h0302);
        send_sample(1'b0, 16'h0103, 16'h0203, 16'h0303);  // dropped
        send_sample(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // dropped
        send_sample(1'b1, 16'h0010, 16'h0020, 16'h0030);

        // Limits 0 and 1: only the first sample of each stream goes out.
        write_limit(32'd0);
        send_sample(1'b0, 16'h0011, 16'h0021, 16'h0031);  // dropped
        send_sample(1'b1, 16'hABCD, 16'h1234, 16'h8000);
        send_sample(1'b0, 16'hABCE, 16'h1235, 16'h8001);  // dropped
        write_limit(32'd1);
        send_sample(1'b1, 16'hFEDC, 16'h0F0F, 16'hF0F0);
        send_sample(1'b0, 16'hFEDD, 16'h0F10, 16'hF0F1);  // dropped

        // Random part across several limit settings.
        write_limit(32'hFFFF_FFFF);
        run_streams(40);
        hold_req = 1'b1;   // receiver holds off while samples keep coming
        run_streams(110);

        write_limit(32'($urandom_range(2, 12)));
        run_streams(100);

        write_limit(32'($urandom_range(0, 1)));
        run_streams(30);

        write_limit($urandom_range(32'h8000_0000, 32'hFFFF_FFFE));
        run_streams(80);

        // Closing stretch with no idling on either side.
        write_limit(32'hFFFF_FFFF);
        quiet = 1'b1;
        run_streams(60);

        drain();
        $display("Summary: %0d samples over %0d limit settings, %0d encoded words checked",
                 samples_sent, limits_written, words_checked);
        $display("Summary: %0d long receiver hold-off(s), %0d mismatch(es)",
                 holds_done, errors);
        if (errors == 0 && words_outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
